// ===== hdl/arp_pkg.sv =====
// shared constants, types and tables for the angular reprojection error core
package arp_pkg;

    localparam int NUM_REGS  = 6;
    localparam int REG_IDX_W = 3;
    localparam int REG_W     = 64;
    localparam int RAY_W     = 32;
    localparam int PT_W      = 32;
    localparam int ANGLE_W   = 31;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_ROW0_COLS01 = 3'd0,
        REG_ROW0_COLS23 = 3'd1,
        REG_ROW1_COLS01 = 3'd2,
        REG_ROW1_COLS23 = 3'd3,
        REG_ROW2_COLS01 = 3'd4,
        REG_ROW2_COLS23 = 3'd5
    } reg_idx_t;

    localparam logic [REG_W-1:0] RST_ROW0_COLS01 = 64'h0000_0000_0001_0000;
    localparam logic [REG_W-1:0] RST_ROW1_COLS01 = 64'h0001_0000_0000_0000;
    localparam logic [REG_W-1:0] RST_ROW2_COLS23 = 64'h0000_0000_0001_0000;

    // square root and divider geometry
    localparam int SQ_IN_W   = 62;
    localparam int SQ_ROOT_W = SQ_IN_W / 2;
    localparam int DIV_N_W   = 64;
    localparam int DIV_Q_W   = 32;

    localparam logic [SQ_ROOT_W-1:0] ONE_Q30  = 31'h4000_0000;
    localparam logic [SQ_IN_W-1:0]   ONE_Q60  = 62'h1 << 60;
    localparam logic [ANGLE_W-1:0]   PI_Q29      = 31'd1686629713;
    localparam logic [ANGLE_W-1:0]   HALF_PI_Q29 = 31'd843314857;

    localparam int CORDIC_N = 30;
    localparam int ZACC_W   = 33;

    // atan(2^-i) in Q3.29, rounded
    function automatic logic [ANGLE_W-1:0] atan_q29(input int unsigned i);
        logic [ANGLE_W-1:0] v;
        begin
            unique case (i)
                0:       v = 31'd421657428;
                1:       v = 31'd248918915;
                2:       v = 31'd131521918;
                3:       v = 31'd66762579;
                4:       v = 31'd33510843;
                5:       v = 31'd16771758;
                6:       v = 31'd8387925;
                7:       v = 31'd4194219;
                8:       v = 31'd2097141;
                9:       v = 31'd1048575;
                default: v = ANGLE_W'(32'd1 << (29 - i));
            endcase
            return v;
        end
    endfunction

    typedef struct packed {
        logic signed [DIV_N_W-1:0] dot;
        logic                      degen;
        logic                      pos_depth;
    } sq1_side_t;

    typedef struct packed {
        logic degen;
        logic pos_depth;
    } div_side_t;

    typedef struct packed {
        logic [SQ_ROOT_W-1:0] xa;
        logic                 neg;
        logic                 degen;
        logic                 pos_depth;
    } sq2_side_t;

endpackage

// ===== hdl/arp_isqrt.sv =====
// pipelined integer square root, one result bit per stage
module arp_isqrt #(
    parameter int SIDE_W = 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_vld,
    input  logic [arp_pkg::SQ_IN_W-1:0]   radicand,
    input  logic [SIDE_W-1:0]             in_side,
    output logic                          out_vld,
    output logic [arp_pkg::SQ_ROOT_W-1:0] root,
    output logic [SIDE_W-1:0]             out_side
);
    import arp_pkg::*;

    localparam int STEPS = SQ_ROOT_W;
    localparam int REM_W = SQ_ROOT_W + 2;
    localparam int CUR_W = REM_W + 2;

    logic                 vld_reg  [0:STEPS];
    logic [REM_W-1:0]     rem_reg  [0:STEPS];
    logic [SQ_ROOT_W-1:0] root_reg [0:STEPS];
    logic [SQ_IN_W-1:0]   bits_reg [0:STEPS];
    logic [SIDE_W-1:0]    side_reg [0:STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= '0;
        root_reg[0] <= '0;
        bits_reg[0] <= radicand;
        side_reg[0] <= in_side;
    end

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        logic [CUR_W-1:0]     cur;
        logic [CUR_W-1:0]     trial;
        logic [REM_W-1:0]     rem_next;
        logic [SQ_ROOT_W-1:0] root_next;

        always_comb
        begin
            cur   = {rem_reg[k], bits_reg[k][SQ_IN_W-1 -: 2]};
            trial = {2'b00, root_reg[k], 2'b01};
            if (cur >= trial)
            begin
                rem_next  = REM_W'(cur - trial);
                root_next = {root_reg[k][SQ_ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = REM_W'(cur);
                root_next = {root_reg[k][SQ_ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k+1]  <= rem_next;
            root_reg[k+1] <= root_next;
            bits_reg[k+1] <= bits_reg[k] << 2;
            side_reg[k+1] <= side_reg[k];
        end
    end

    assign out_vld  = vld_reg[STEPS];
    assign root     = root_reg[STEPS];
    assign out_side = side_reg[STEPS];

endmodule

// ===== hdl/arp_div.sv =====
// pipelined signed-by-unsigned restoring divider, one quotient bit per stage
module arp_div #(
    parameter int SIDE_W = 1
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_vld,
    input  logic signed [arp_pkg::DIV_N_W-1:0]  dividend,
    input  logic [arp_pkg::SQ_ROOT_W-1:0]       divisor,
    input  logic [SIDE_W-1:0]                   in_side,
    output logic                                out_vld,
    output logic [arp_pkg::DIV_Q_W-1:0]         quot,
    output logic                                neg,
    output logic [SIDE_W-1:0]                   out_side
);
    import arp_pkg::*;

    localparam int STEPS = DIV_Q_W;

    logic                 vld_reg  [0:STEPS];
    logic [DIV_N_W-1:0]   rem_reg  [0:STEPS];
    logic [SQ_ROOT_W-1:0] dvs_reg  [0:STEPS];
    logic [DIV_Q_W-1:0]   quot_reg [0:STEPS];
    logic                 neg_reg  [0:STEPS];
    logic [SIDE_W-1:0]    side_reg [0:STEPS];

    logic [DIV_N_W-1:0] mag_next;

    // quotient truncates toward zero, so work on the magnitude
    always_comb
    begin
        mag_next = dividend[DIV_N_W-1] ? DIV_N_W'(-dividend) : DIV_N_W'(dividend);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= mag_next;
        dvs_reg[0]  <= divisor;
        quot_reg[0] <= '0;
        neg_reg[0]  <= dividend[DIV_N_W-1];
        side_reg[0] <= in_side;
    end

    for (genvar j = 0; j < STEPS; j++)
    begin : g_step
        localparam int SH = STEPS - 1 - j;
        logic [DIV_N_W-1:0] dshift;
        logic [DIV_N_W-1:0] rem_next;
        logic               qbit;

        always_comb
        begin
            dshift = DIV_N_W'(dvs_reg[j]) << SH;
            qbit   = (rem_reg[j] >= dshift);
            rem_next = qbit ? (rem_reg[j] - dshift) : rem_reg[j];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j+1] <= 1'b0;
            end
            else
            begin
                vld_reg[j+1] <= vld_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[j+1]  <= rem_next;
            dvs_reg[j+1]  <= dvs_reg[j];
            quot_reg[j+1] <= {quot_reg[j][DIV_Q_W-2:0], qbit};
            neg_reg[j+1]  <= neg_reg[j];
            side_reg[j+1] <= side_reg[j];
        end
    end

    assign out_vld  = vld_reg[STEPS];
    assign quot     = quot_reg[STEPS];
    assign neg      = neg_reg[STEPS];
    assign out_side = side_reg[STEPS];

endmodule

// ===== hdl/angular_reprojection_error_core.sv =====
// top level: pose transform, normalization, cosine, arc cosine pipeline
//
// A transaction is taken on every clock where start is high; busy stays low, so a new
// ray and point may enter each cycle. Each transaction gives one result, in order. done
// is high for a single cycle with each result. The pipeline is made of the bit-per-stage
// square roots (31 stages plus an input register each, used twice), the bit-per-stage
// divider (32 plus an input register) and the 30 CORDIC vectoring stages, on top of
// eight transform and normalization stages and the clamp and result registers. Pose
// registers are written through wr_en/wr_index/wr_data and must only change while no
// transaction is in flight; writes to indexes past the last register are dropped.
module angular_reprojection_error_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [arp_pkg::REG_IDX_W-1:0] wr_index,
    input  logic [arp_pkg::REG_W-1:0]     wr_data,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [arp_pkg::RAY_W-1:0] ray_x,
    input  logic signed [arp_pkg::RAY_W-1:0] ray_y,
    input  logic signed [arp_pkg::RAY_W-1:0] ray_z,
    input  logic signed [arp_pkg::PT_W-1:0]  point_x,
    input  logic signed [arp_pkg::PT_W-1:0]  point_y,
    input  logic signed [arp_pkg::PT_W-1:0]  point_z,
    output logic                          done,
    output logic [arp_pkg::ANGLE_W-1:0]   angle,
    output logic                          positive_depth,
    output logic                          degenerate
);
    import arp_pkg::*;

    localparam int PROD_W = 2 * PT_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int P_W    = 50;
    localparam int MAG_W  = P_W - 1;
    localparam int GRP_N  = 7;
    localparam int Q_W    = SQ_ROOT_W;
    localparam int QQ_W   = 2 * Q_W;
    localparam int RQ_W   = RAY_W + Q_W;
    localparam int XY_W   = 64;

    assign busy = 1'b0;

    // configuration
    logic [REG_W-1:0] cfg_reg [0:NUM_REGS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[REG_ROW0_COLS01] <= RST_ROW0_COLS01;
            cfg_reg[REG_ROW0_COLS23] <= '0;
            cfg_reg[REG_ROW1_COLS01] <= RST_ROW1_COLS01;
            cfg_reg[REG_ROW1_COLS23] <= '0;
            cfg_reg[REG_ROW2_COLS01] <= '0;
            cfg_reg[REG_ROW2_COLS23] <= RST_ROW2_COLS23;
        end
        else if (wr_en && (wr_index < REG_IDX_W'(NUM_REGS)))
        begin
            cfg_reg[wr_index] <= wr_data;
        end
    end

    logic signed [PT_W-1:0] mat   [0:2][0:2];
    logic signed [PT_W-1:0] trans [0:2];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mat[i][0] = cfg_reg[2*i][31:0];
            mat[i][1] = cfg_reg[2*i][63:32];
            mat[i][2] = cfg_reg[2*i+1][31:0];
            trans[i]  = cfg_reg[2*i+1][63:32];
        end
    end

    // stage 0: input register
    logic                    s0_vld_reg;
    logic signed [RAY_W-1:0] s0_ray_reg [0:2];
    logic signed [PT_W-1:0]  s0_pt_reg  [0:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
        end
        else
        begin
            s0_vld_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_ray_reg[0] <= ray_x;
        s0_ray_reg[1] <= ray_y;
        s0_ray_reg[2] <= ray_z;
        s0_pt_reg[0]  <= point_x;
        s0_pt_reg[1]  <= point_y;
        s0_pt_reg[2]  <= point_z;
    end

    // stage 1: nine rotation products
    logic                     s1_vld_reg;
    logic signed [PROD_W-1:0] s1_prod_next [0:2][0:2];
    logic signed [PROD_W-1:0] s1_prod_reg  [0:2][0:2];
    logic signed [RAY_W-1:0]  s1_ray_reg   [0:2];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                s1_prod_next[i][j] = mat[i][j] * s0_pt_reg[j];
            end
        end
    end

    // stage 2: row sums plus translation, floored to Q32.16
    logic                   s2_vld_reg;
    logic signed [SUM_W-1:0] s2_sum [0:2];
    logic signed [P_W-1:0]  s2_p_next [0:2];
    logic signed [P_W-1:0]  s2_p_reg  [0:2];
    logic signed [RAY_W-1:0] s2_ray_reg [0:2];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s2_sum[i] = SUM_W'(s1_prod_reg[i][0]) + SUM_W'(s1_prod_reg[i][1])
                      + SUM_W'(s1_prod_reg[i][2]) + (SUM_W'(trans[i]) <<< 16);
            s2_p_next[i] = P_W'(s2_sum[i] >>> 16);
        end
    end

    // stage 3: magnitudes and their maximum
    logic                    s3_vld_reg;
    logic [MAG_W-1:0]        s3_mag [0:2];
    logic [MAG_W-1:0]        s3_max_next;
    logic [MAG_W-1:0]        s3_max_reg;
    logic                    s3_posd_next;
    logic                    s3_posd_reg;
    logic signed [P_W-1:0]   s3_p_reg   [0:2];
    logic signed [RAY_W-1:0] s3_ray_reg [0:2];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s3_mag[i] = s2_p_reg[i][P_W-1] ? MAG_W'(-s2_p_reg[i]) : MAG_W'(s2_p_reg[i]);
        end
        s3_max_next = s3_mag[0];
        if (s3_mag[1] > s3_max_next)
        begin
            s3_max_next = s3_mag[1];
        end
        if (s3_mag[2] > s3_max_next)
        begin
            s3_max_next = s3_mag[2];
        end
        s3_posd_next = !s2_p_reg[2][P_W-1] && (s2_p_reg[2] != '0);
    end

    // stage 4: leading-one search, per byte group
    logic                    s4_vld_reg;
    logic [GRP_N*8-1:0]      s4_pad;
    logic [GRP_N-1:0]        s4_nz_next;
    logic [GRP_N-1:0]        s4_nz_reg;
    logic [2:0]              s4_lpos_next [0:GRP_N-1];
    logic [2:0]              s4_lpos_reg  [0:GRP_N-1];
    logic                    s4_posd_reg;
    logic signed [P_W-1:0]   s4_p_reg   [0:2];
    logic signed [RAY_W-1:0] s4_ray_reg [0:2];

    always_comb
    begin
        s4_pad = {{(GRP_N*8-MAG_W){1'b0}}, s3_max_reg};
        for (int g = 0; g < GRP_N; g++)
        begin
            s4_nz_next[g]   = |s4_pad[g*8 +: 8];
            s4_lpos_next[g] = 3'd0;
            for (int b = 0; b < 8; b++)
            begin
                if (s4_pad[g*8+b])
                begin
                    s4_lpos_next[g] = 3'(b);
                end
            end
        end
    end

    // stage 5: pick the top group and derive the normalizing shift
    logic                    s5_vld_reg;
    logic [5:0]              s5_lead;
    logic                    s5_shr_next;
    logic                    s5_shr_reg;
    logic [4:0]              s5_amt_next;
    logic [4:0]              s5_amt_reg;
    logic                    s5_degen_next;
    logic                    s5_degen_reg;
    logic                    s5_posd_reg;
    logic signed [P_W-1:0]   s5_p_reg   [0:2];
    logic signed [RAY_W-1:0] s5_ray_reg [0:2];

    always_comb
    begin
        s5_lead = '0;
        for (int g = 0; g < GRP_N; g++)
        begin
            if (s4_nz_reg[g])
            begin
                s5_lead = {3'(g), s4_lpos_reg[g]};
            end
        end
        // bring the largest magnitude into [2^29, 2^30)
        if (s5_lead >= 6'd30)
        begin
            s5_shr_next = 1'b1;
            s5_amt_next = 5'(s5_lead - 6'd29);
        end
        else
        begin
            s5_shr_next = 1'b0;
            s5_amt_next = 5'(6'd29 - s5_lead);
        end
        s5_degen_next = ~|s4_nz_reg;
    end

    // stage 6: apply the shift
    logic                    s6_vld_reg;
    logic signed [Q_W-1:0]   s6_q_next [0:2];
    logic signed [Q_W-1:0]   s6_q_reg  [0:2];
    logic                    s6_degen_reg;
    logic                    s6_posd_reg;
    logic signed [RAY_W-1:0] s6_ray_reg [0:2];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s6_q_next[i] = s5_shr_reg ? Q_W'(s5_p_reg[i] >>> s5_amt_reg)
                                      : Q_W'(s5_p_reg[i] <<< s5_amt_reg);
        end
    end

    // stage 7: squares and ray products
    logic                   s7_vld_reg;
    logic signed [QQ_W-1:0] s7_qq_next [0:2];
    logic signed [QQ_W-1:0] s7_qq_reg  [0:2];
    logic signed [RQ_W-1:0] s7_rq_next [0:2];
    logic signed [RQ_W-1:0] s7_rq_reg  [0:2];
    logic                   s7_degen_reg;
    logic                   s7_posd_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s7_qq_next[i] = s6_q_reg[i] * s6_q_reg[i];
            s7_rq_next[i] = s6_ray_reg[i] * s6_q_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            s6_vld_reg <= 1'b0;
            s7_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= s0_vld_reg;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
            s6_vld_reg <= s5_vld_reg;
            s7_vld_reg <= s6_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_prod_reg  <= s1_prod_next;
        s1_ray_reg   <= s0_ray_reg;
        s2_p_reg     <= s2_p_next;
        s2_ray_reg   <= s1_ray_reg;
        s3_max_reg   <= s3_max_next;
        s3_posd_reg  <= s3_posd_next;
        s3_p_reg     <= s2_p_reg;
        s3_ray_reg   <= s2_ray_reg;
        s4_nz_reg    <= s4_nz_next;
        s4_lpos_reg  <= s4_lpos_next;
        s4_posd_reg  <= s3_posd_reg;
        s4_p_reg     <= s3_p_reg;
        s4_ray_reg   <= s3_ray_reg;
        s5_shr_reg   <= s5_shr_next;
        s5_amt_reg   <= s5_amt_next;
        s5_degen_reg <= s5_degen_next;
        s5_posd_reg  <= s4_posd_reg;
        s5_p_reg     <= s4_p_reg;
        s5_ray_reg   <= s4_ray_reg;
        s6_q_reg     <= s6_q_next;
        s6_degen_reg <= s5_degen_reg;
        s6_posd_reg  <= s5_posd_reg;
        s6_ray_reg   <= s5_ray_reg;
        s7_qq_reg    <= s7_qq_next;
        s7_rq_reg    <= s7_rq_next;
        s7_degen_reg <= s6_degen_reg;
        s7_posd_reg  <= s6_posd_reg;
    end

    // norm of the scaled point
    logic [SQ_IN_W-1:0] n2;
    sq1_side_t          sq1_in;
    sq1_side_t          sq1_out;
    logic               sq1_vld;
    logic [Q_W-1:0]     sq1_root;

    always_comb
    begin
        n2 = SQ_IN_W'(s7_qq_reg[0]) + SQ_IN_W'(s7_qq_reg[1]) + SQ_IN_W'(s7_qq_reg[2]);
        sq1_in.dot = DIV_N_W'(s7_rq_reg[0]) + DIV_N_W'(s7_rq_reg[1])
                   + DIV_N_W'(s7_rq_reg[2]);
        sq1_in.degen     = s7_degen_reg;
        sq1_in.pos_depth = s7_posd_reg;
    end

    arp_isqrt #(
        .SIDE_W ($bits(sq1_side_t))
    ) u_norm_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (s7_vld_reg),
        .radicand (n2),
        .in_side  (sq1_in),
        .out_vld  (sq1_vld),
        .root     (sq1_root),
        .out_side (sq1_out)
    );

    // cosine = dot / norm
    div_side_t          div_in;
    div_side_t          div_out;
    logic               div_vld;
    logic [DIV_Q_W-1:0] div_quot;
    logic               div_neg;

    assign div_in.degen     = sq1_out.degen;
    assign div_in.pos_depth = sq1_out.pos_depth;

    arp_div #(
        .SIDE_W ($bits(div_side_t))
    ) u_cos_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (sq1_vld),
        .dividend (sq1_out.dot),
        .divisor  (sq1_root),
        .in_side  (div_in),
        .out_vld  (div_vld),
        .quot     (div_quot),
        .neg      (div_neg),
        .out_side (div_out)
    );

    // clamp the cosine to one and square it
    logic               cl_vld_reg;
    logic [Q_W-1:0]     cl_xa_next;
    logic [Q_W-1:0]     cl_xa_reg;
    logic               cl_neg_next;
    logic               cl_neg_reg;
    logic [SQ_IN_W-1:0] cl_sq_next;
    logic [SQ_IN_W-1:0] cl_sq_reg;
    logic               cl_degen_reg;
    logic               cl_posd_reg;

    always_comb
    begin
        if (div_quot[DIV_Q_W-1] || (div_quot[Q_W-1:0] > ONE_Q30))
        begin
            cl_xa_next = ONE_Q30;
        end
        else
        begin
            cl_xa_next = div_quot[Q_W-1:0];
        end
        cl_neg_next = div_neg && (cl_xa_next != '0);
        cl_sq_next  = cl_xa_next * cl_xa_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cl_vld_reg <= 1'b0;
        end
        else
        begin
            cl_vld_reg <= div_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        cl_xa_reg    <= cl_xa_next;
        cl_neg_reg   <= cl_neg_next;
        cl_sq_reg    <= cl_sq_next;
        cl_degen_reg <= div_out.degen;
        cl_posd_reg  <= div_out.pos_depth;
    end

    // sine = sqrt(1 - cos^2)
    logic [SQ_IN_W-1:0] sin_arg;
    sq2_side_t          sq2_in;
    sq2_side_t          sq2_out;
    logic               sq2_vld;
    logic [Q_W-1:0]     sq2_root;

    always_comb
    begin
        sin_arg          = ONE_Q60 - cl_sq_reg;
        sq2_in.xa        = cl_xa_reg;
        sq2_in.neg       = cl_neg_reg;
        sq2_in.degen     = cl_degen_reg;
        sq2_in.pos_depth = cl_posd_reg;
    end

    arp_isqrt #(
        .SIDE_W ($bits(sq2_side_t))
    ) u_sin_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (cl_vld_reg),
        .radicand (sin_arg),
        .in_side  (sq2_in),
        .out_vld  (sq2_vld),
        .root     (sq2_root),
        .out_side (sq2_out)
    );

    // CORDIC vectoring on (|cos|, sin)
    logic                     cr_vld_reg   [0:CORDIC_N];
    logic signed [XY_W-1:0]   cr_x_reg     [0:CORDIC_N];
    logic signed [XY_W-1:0]   cr_y_reg     [0:CORDIC_N];
    logic signed [ZACC_W-1:0] cr_z_reg     [0:CORDIC_N];
    logic                     cr_szero_reg [0:CORDIC_N];
    logic                     cr_neg_reg   [0:CORDIC_N];
    logic                     cr_degen_reg [0:CORDIC_N];
    logic                     cr_posd_reg  [0:CORDIC_N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cr_vld_reg[0] <= 1'b0;
        end
        else
        begin
            cr_vld_reg[0] <= sq2_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        cr_x_reg[0]     <= $signed({3'b000, sq2_out.xa, 30'd0});
        cr_y_reg[0]     <= $signed({3'b000, sq2_root, 30'd0});
        cr_z_reg[0]     <= '0;
        cr_szero_reg[0] <= (sq2_root == '0);
        cr_neg_reg[0]   <= sq2_out.neg;
        cr_degen_reg[0] <= sq2_out.degen;
        cr_posd_reg[0]  <= sq2_out.pos_depth;
    end

    for (genvar k = 0; k < CORDIC_N; k++)
    begin : g_cordic
        localparam logic [ANGLE_W-1:0] ATAN_K = atan_q29(k);
        logic signed [XY_W-1:0]   xs;
        logic signed [XY_W-1:0]   ys;
        logic signed [XY_W-1:0]   x_next;
        logic signed [XY_W-1:0]   y_next;
        logic signed [ZACC_W-1:0] z_next;

        always_comb
        begin
            xs = cr_x_reg[k] >>> k;
            ys = cr_y_reg[k] >>> k;
            if (cr_y_reg[k] > 0)
            begin
                x_next = cr_x_reg[k] + ys;
                y_next = cr_y_reg[k] - xs;
                z_next = cr_z_reg[k] + $signed({2'b00, ATAN_K});
            end
            else
            begin
                x_next = cr_x_reg[k] - ys;
                y_next = cr_y_reg[k] + xs;
                z_next = cr_z_reg[k] - $signed({2'b00, ATAN_K});
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cr_vld_reg[k+1] <= 1'b0;
            end
            else
            begin
                cr_vld_reg[k+1] <= cr_vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            cr_x_reg[k+1]     <= x_next;
            cr_y_reg[k+1]     <= y_next;
            cr_z_reg[k+1]     <= z_next;
            cr_szero_reg[k+1] <= cr_szero_reg[k];
            cr_neg_reg[k+1]   <= cr_neg_reg[k];
            cr_degen_reg[k+1] <= cr_degen_reg[k];
            cr_posd_reg[k+1]  <= cr_posd_reg[k];
        end
    end

    // result register
    logic               out_vld_reg;
    logic [ANGLE_W-1:0] out_angle_next;
    logic [ANGLE_W-1:0] out_angle_reg;
    logic [ANGLE_W-1:0] z_clamped;
    logic               out_posd_reg;
    logic               out_degen_reg;

    always_comb
    begin
        if (cr_z_reg[CORDIC_N] < 0)
        begin
            z_clamped = '0;
        end
        else if (cr_z_reg[CORDIC_N] > $signed({2'b00, HALF_PI_Q29}))
        begin
            z_clamped = HALF_PI_Q29;
        end
        else
        begin
            z_clamped = cr_z_reg[CORDIC_N][ANGLE_W-1:0];
        end

        priority if (cr_degen_reg[CORDIC_N])
        begin
            out_angle_next = HALF_PI_Q29;
        end
        else if (cr_szero_reg[CORDIC_N])
        begin
            out_angle_next = cr_neg_reg[CORDIC_N] ? PI_Q29 : '0;
        end
        else
        begin
            out_angle_next = cr_neg_reg[CORDIC_N] ? (PI_Q29 - z_clamped) : z_clamped;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= cr_vld_reg[CORDIC_N];
        end
    end

    always_ff @(posedge clk)
    begin
        out_angle_reg <= out_angle_next;
        out_posd_reg  <= cr_posd_reg[CORDIC_N];
        out_degen_reg <= cr_degen_reg[CORDIC_N];
    end

    assign done           = out_vld_reg;
    assign angle          = out_angle_reg;
    assign positive_depth = out_posd_reg;
    assign degenerate     = out_degen_reg;

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for the angular reprojection error core
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import arp_pkg::*;

    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam longint ONE_Q30_L     = 64'sd1 << 30;
    localparam longint PI_Q29_L      = 1686629713;
    localparam longint HALF_PI_Q29_L = 843314857;
    localparam longint QTR_PI_Q29_L  = 421657428;
    localparam int     N_ITERS       = 30;
    localparam int     DRAIN_CYCLES  = 160;
    localparam longint CYCLE_LIMIT   = 2000000;

    typedef struct {
        logic signed [RAY_W-1:0] ray [3];
        logic signed [PT_W-1:0]  pt [3];
    } sample_t;

    typedef struct {
        logic [ANGLE_W-1:0] angle;
        logic               pos_depth;
        logic               degen;
    } err_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic wr_en = 1'b0;
    logic [REG_IDX_W-1:0] wr_index = '0;
    logic [REG_W-1:0] wr_data = '0;
    logic start = 1'b0;
    logic busy;
    logic signed [RAY_W-1:0] ray_x = '0, ray_y = '0, ray_z = '0;
    logic signed [PT_W-1:0]  point_x = '0, point_y = '0, point_z = '0;
    logic done;
    logic [ANGLE_W-1:0] angle;
    logic positive_depth;
    logic degenerate;

    angular_reprojection_error_core u_top (
        .clk(clk), .rst_n(rst_n), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
        .start(start), .busy(busy), .ray_x(ray_x), .ray_y(ray_y), .ray_z(ray_z),
        .point_x(point_x), .point_y(point_y), .point_z(point_z), .done(done),
        .angle(angle), .positive_depth(positive_depth), .degenerate(degenerate)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    logic [REG_W-1:0] pose [NUM_REGS];
    longint atan_lut [N_ITERS];
    sample_t pending_samples [$];
    err_t    expected_errs [$];
    int      error_count = 0;
    bit      burst_mode = 1'b0;
    longint  cycle_count = 0;

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned res, bit_v;
        res = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > n)
            bit_v >>= 2;
        while (bit_v != 0)
        begin
            if (n >= res + bit_v)
            begin
                n -= res + bit_v;
                res = (res >> 1) + bit_v;
            end
            else
                res >>= 1;
            bit_v >>= 2;
        end
        return res;
    endfunction

    // atan(1/n) by its series with 62 fraction bits, rounded to Q3.29
    function automatic longint atan_recip(input longint unsigned n);
        longint unsigned pw, acc, k;
        pw = (64'd1 << 62) / n;
        acc = 0;
        k = 0;
        while (pw != 0)
        begin
            if (k[0] == 1'b0)
                acc += pw / (2 * k + 1);
            else
                acc -= pw / (2 * k + 1);
            pw /= n * n;
            k++;
        end
        return longint'((acc + (64'd1 << 32)) >> 33);
    endfunction

    function automatic logic signed [31:0] half(input logic [REG_W-1:0] v, input bit hi);
        return hi ? v[63:32] : v[31:0];
    endfunction

    // camera-frame point in Q32.16, floored from the exact Q32.32 sum
    function automatic void cam_point(input sample_t s, output longint p [3]);
        logic signed [127:0] acc;
        for (int i = 0; i < 3; i++)
        begin
            acc = 128'(longint'(half(pose[2*i], 0)) * longint'(s.pt[0]));
            acc += 128'(longint'(half(pose[2*i], 1)) * longint'(s.pt[1]));
            acc += 128'(longint'(half(pose[2*i+1], 0)) * longint'(s.pt[2]));
            acc += 128'(longint'(half(pose[2*i+1], 1))) <<< 16;
            p[i] = longint'(acc >>> 16);
        end
    endfunction

    // bring the largest magnitude into [2^29, 2^30)
    function automatic void normalize_vec(input longint p [3], output longint q [3]);
        longint m, mag, mul;
        int sh;
        m = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag = p[i] < 0 ? -p[i] : p[i];
            if (mag > m)
                m = mag;
        end
        if (m >= ONE_Q30_L)
        begin
            sh = 0;
            while ((m >>> sh) >= ONE_Q30_L)
                sh++;
            for (int i = 0; i < 3; i++)
                q[i] = p[i] >>> sh;
        end
        else
        begin
            mul = 1;
            while (m * mul < (ONE_Q30_L >>> 1))
                mul *= 2;
            for (int i = 0; i < 3; i++)
                q[i] = p[i] * mul;
        end
    endfunction

    function automatic longint arc_cos(input longint c);
        longint xa, x, y, z, xs, ys;
        longint unsigned s;
        xa = c < 0 ? -c : c;
        s = int_sqrt((64'd1 << 60) - longint'(xa * xa));
        if (s == 0)
            return c < 0 ? PI_Q29_L : 0;
        x = xa <<< 30;
        y = longint'(s) <<< 30;
        z = 0;
        for (int i = 0; i < N_ITERS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x += ys; y -= xs; z += atan_lut[i];
            end
            else
            begin
                x -= ys; y += xs; z -= atan_lut[i];
            end
        end
        if (z < 0)
            z = 0;
        if (z > HALF_PI_Q29_L)
            z = HALF_PI_Q29_L;
        return c < 0 ? PI_Q29_L - z : z;
    endfunction

    function automatic err_t predict_error(input sample_t s);
        err_t r;
        longint p [3], q [3], dot, c;
        longint unsigned n2;
        cam_point(s, p);
        r.pos_depth = p[2] >= 1;
        r.degen = (p[0] == 0) && (p[1] == 0) && (p[2] == 0);
        if (r.degen)
        begin
            r.angle = ANGLE_W'(HALF_PI_Q29_L);
            return r;
        end
        normalize_vec(p, q);
        n2 = 0;
        dot = 0;
        for (int i = 0; i < 3; i++)
        begin
            n2 += longint'(q[i] * q[i]);
            dot += longint'(s.ray[i]) * q[i];
        end
        c = dot / longint'(int_sqrt(n2));
        if (c > ONE_Q30_L)
            c = ONE_Q30_L;
        if (c < -ONE_Q30_L)
            c = -ONE_Q30_L;
        r.angle = ANGLE_W'(arc_cos(c));
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // driver: start/busy handshake, prediction taken at the accepting edge
    int gap_left = 0;
    always @(posedge clk)
    begin
        sample_t s;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                s.ray[0] = ray_x; s.ray[1] = ray_y; s.ray[2] = ray_z;
                s.pt[0] = point_x; s.pt[1] = point_y; s.pt[2] = point_z;
                expected_errs.push_back(predict_error(s));
            end
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (pending_samples.size() > 0)
                begin
                    s = pending_samples.pop_front();
                    ray_x <= s.ray[0]; ray_y <= s.ray[1]; ray_z <= s.ray[2];
                    point_x <= s.pt[0]; point_y <= s.pt[1]; point_z <= s.pt[2];
                    start <= 1'b1;
                    gap_left = pick_gap();
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor: every done transaction checked against the oldest prediction
    always @(posedge clk)
    begin
        err_t e;
        if (rst_n && done)
        begin
            if (expected_errs.size() == 0)
                report("unexpected result, angle", angle, -1);
            else
            begin
                e = expected_errs.pop_front();
                if (angle !== e.angle)
                    report("angle", angle, e.angle);
                if (positive_depth !== e.pos_depth)
                    report("positive_depth", positive_depth, e.pos_depth);
                if (degenerate !== e.degen)
                    report("degenerate", degenerate, e.degen);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [REG_W-1:0] v);
        @(posedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= v;
        if (idx < NUM_REGS)
            pose[idx] = v;
    endtask

    task automatic end_writes();
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_samples.size() > 0 || start || expected_errs.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic sample_t mk(input longint rx, input longint ry, input longint rz,
                                   input longint px, input longint py, input longint pz);
        sample_t s;
        s.ray[0] = RAY_W'(rx); s.ray[1] = RAY_W'(ry); s.ray[2] = RAY_W'(rz);
        s.pt[0] = PT_W'(px); s.pt[1] = PT_W'(py); s.pt[2] = PT_W'(pz);
        return s;
    endfunction

    function automatic longint rand_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return longint'(signed'($urandom()));
        if (r < 7)
            return longint'($urandom_range(0, 2097151)) - 1048576;
        return longint'($urandom_range(0, 65535)) - 32768;
    endfunction

    // unit ray to the point or random vector, noise/flip optional; or random
    function automatic sample_t rand_sample();
        sample_t s;
        longint p [3], q [3], n;
        int mode;
        for (int i = 0; i < 3; i++)
            s.pt[i] = PT_W'(rand_coord());
        mode = $urandom_range(0, 9);
        cam_point(s, p);
        if (mode < 3 || (p[0] == 0 && p[1] == 0 && p[2] == 0))
        begin
            for (int i = 0; i < 3; i++)
                s.ray[i] = $urandom();
            return s;
        end
        if (mode < 5)
            for (int i = 0; i < 3; i++)
                p[i] = longint'(signed'($urandom())) >>> $urandom_range(0, 20);
        if (p[0] == 0 && p[1] == 0 && p[2] == 0)
            p[2] = 1;
        normalize_vec(p, q);
        n = longint'(int_sqrt(longint'(q[0]*q[0] + q[1]*q[1] + q[2]*q[2])));
        for (int i = 0; i < 3; i++)
        begin
            s.ray[i] = RAY_W'((q[i] <<< 30) / n);
            if ($urandom_range(0, 1))
                s.ray[i] = RAY_W'(longint'(s.ray[i])
                                  + (longint'($urandom_range(0, 2047)) - 1024));
            if (mode == 9)
                s.ray[i] = -s.ray[i];
        end
        return s;
    endfunction

    function automatic logic [REG_W-1:0] rand_entry_pair(input int kind);
        logic [31:0] a, b;
        unique case (kind)
            0: begin
                a = $urandom_range(0, 262143) - 131072;
                b = $urandom_range(0, 262143) - 131072;
            end
            1: begin a = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                     b = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000; end
            default: begin a = $urandom(); b = $urandom(); end
        endcase
        return {b, a};
    endfunction

    initial
    begin
        longint one;
        atan_lut[0] = QTR_PI_Q29_L;
        for (int i = 1; i < N_ITERS; i++)
            atan_lut[i] = atan_recip(64'd1 << i);
        pose[REG_ROW0_COLS01] = RST_ROW0_COLS01;
        pose[REG_ROW0_COLS23] = '0;
        pose[REG_ROW1_COLS01] = RST_ROW1_COLS01;
        pose[REG_ROW1_COLS23] = '0;
        pose[REG_ROW2_COLS01] = '0;
        pose[REG_ROW2_COLS23] = RST_ROW2_COLS23;
        one = ONE_Q30_L;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed corners under the reset (identity) pose
        pending_samples.push_back(mk(0, 0, one, 0, 0, 0));
        pending_samples.push_back(mk(0, 0, one, 0, 0, 1));
        pending_samples.push_back(mk(0, 0, one, 0, 0, -1));
        pending_samples.push_back(mk(0, 0, one, 0, 0, 32'h7FFF_FFFF));
        pending_samples.push_back(mk(0, one, 0, 1, 0, 0));
        pending_samples.push_back(mk(-one, 0, 0, 65536, 0, 0));
        pending_samples.push_back(mk(-32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000,
                                     -32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000));
        pending_samples.push_back(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        pending_samples.push_back(mk(-32'sh8000_0000, 32'h7FFF_FFFF, 0,
                                     32'h7FFF_FFFF, -32'sh8000_0000, 0));
        pending_samples.push_back(mk(0, 0, 0, 1234567, -7654321, 999));
        pending_samples.push_back(mk(one, 0, 0, one, 0, 0));
        pending_samples.push_back(mk(one, 0, 0, (one >>> 1) - 1, 0, 0));
        pending_samples.push_back(mk(one, one, one, 100, 100, 100));
        pending_samples.push_back(mk(0, -one, 0, 0, 5, -3));
        pending_samples.push_back(mk(0, 0, -one, 0, 0, -32'sh8000_0000));
        for (int i = 0; i < 5; i++)
            pending_samples.push_back(rand_sample());
        for (int i = 0; i < 120; i++)
            pending_samples.push_back(rand_sample());
        wait_idle();

        for (int ph = 0; ph < 6; ph++)
        begin
            unique case (ph)
                0: begin
                    write_reg(REG_ROW0_COLS01, 64'h0000_0000_0001_0000);
                    write_reg(REG_ROW0_COLS23, {32'($urandom_range(0, 65535)), 32'd0});
                    write_reg(REG_ROW1_COLS01, 64'h0001_0000_0000_0000);
                    write_reg(REG_ROW1_COLS23, {32'hFFFF_0000, 32'd0});
                    write_reg(REG_ROW2_COLS01, 64'd0);
                    write_reg(REG_ROW2_COLS23, 64'h0000_0000_0001_0000);
                end
                1: for (int r = 0; r < NUM_REGS; r++)
                    write_reg(REG_IDX_W'(r), rand_entry_pair(0));
                2: for (int r = 0; r < NUM_REGS; r++)
                    write_reg(REG_IDX_W'(r), rand_entry_pair(1));
                3: for (int r = 0; r < NUM_REGS; r++)
                    write_reg(REG_IDX_W'(r), 64'd0);
                4: begin
                    for (int r = 0; r < NUM_REGS; r++)
                        write_reg(REG_IDX_W'(r), rand_entry_pair(2));
                    write_reg(REG_UNUSED, 64'hDEAD_BEEF_0BAD_F00D);
                end
                default: for (int r = 0; r < NUM_REGS; r++)
                    write_reg(REG_IDX_W'(r), rand_entry_pair(0));
            endcase
            end_writes();
            burst_mode = (ph % 2) == 1;
            for (int i = 0; i < (ph == 3 ? 30 : 140); i++)
                pending_samples.push_back(rand_sample());
            wait_idle();
        end

        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

// ===== angular_reprojection_error_core.f =====
hdl/arp_pkg.sv
hdl/arp_isqrt.sv
hdl/arp_div.sv
hdl/angular_reprojection_error_core.sv
tb/tb.sv
